// File: hw/rtl/bnl_pkg.sv
// shared constants for the box normalized l1 loss block
`default_nettype none
package bnl_pkg;

  localparam int unsigned NORM_W  = 16;
  localparam int unsigned GRAD_W  = 17;
  localparam int unsigned LOSS_W  = 34;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned BATCH_W = 11;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned LANES   = 4;

  localparam logic [NORM_W-1:0]  NORM_FLOOR  = 16'd26;
  localparam logic [NORM_W-1:0]  NORM_MAX    = 16'hFFFF;
  localparam logic [NORM_W-1:0]  NORM_ONE    = 16'd256;
  localparam logic [LOSS_W-1:0]  LOSS_MAX    = {LOSS_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [NORM_W-1:0]  REF_SIZE_RST = 16'd256;
  localparam logic [BATCH_W-1:0] BATCH_RST   = 11'd1;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_REF_SIZE    = 1'b0;
  localparam logic [0:0] REG_BATCH_COUNT = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/bnl_in_if.sv
// input channel carrying one box pair per word
`default_nettype none
interface bnl_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pred_x1;
  logic signed [COORD_WIDTH-1:0] pred_y1;
  logic signed [COORD_WIDTH-1:0] pred_x2;
  logic signed [COORD_WIDTH-1:0] pred_y2;
  logic signed [COORD_WIDTH-1:0] gt_x1;
  logic signed [COORD_WIDTH-1:0] gt_y1;
  logic signed [COORD_WIDTH-1:0] gt_x2;
  logic signed [COORD_WIDTH-1:0] gt_y2;
  logic                          end_of_pass;

  modport source (
    output valid, pred_x1, pred_y1, pred_x2, pred_y2,
           gt_x1, gt_y1, gt_x2, gt_y2, end_of_pass,
    input  ready
  );
  modport sink (
    input  valid, pred_x1, pred_y1, pred_x2, pred_y2,
           gt_x1, gt_y1, gt_x2, gt_y2, end_of_pass,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/bnl_out_if.sv
// output channel carrying one loss result per word
`default_nettype none
interface bnl_out_if;
  logic               valid;
  logic               ready;
  logic        [33:0] location_loss;
  logic        [15:0] width_norm;
  logic        [15:0] height_norm;
  logic signed [16:0] grad_x1;
  logic signed [16:0] grad_y1;
  logic signed [16:0] grad_x2;
  logic signed [16:0] grad_y2;
  logic        [47:0] batch_loss;
  logic               pass_done;

  modport source (
    output valid, location_loss, width_norm, height_norm,
           grad_x1, grad_y1, grad_x2, grad_y2, batch_loss, pass_done,
    input  ready
  );
  modport sink (
    input  valid, location_loss, width_norm, height_norm,
           grad_x1, grad_y1, grad_x2, grad_y2, batch_loss, pass_done,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/box_normalized_l1_loss.sv
// top level of the size normalized l1 box regression loss block
`default_nettype none
// Takes one box pair (four predicted and four ground truth signed Q8.8
// corners) per input word and returns one result word: the weighted L1 loss
// of the location, the width and height norms and four sign gradients; on the
// word marked end_of_pass it also returns the running loss sum divided by
// batch_count and clears the sum. One word is in work at a time. A word passes
// through the two norm dividers, which run side by side one quotient bit a
// cycle, then the lane multiply, the merge add, the accumulate step and the
// output load. The last word of a pass also runs the 48 bit batch division,
// one bit a cycle. The output register lets the next word be taken while a
// result waits. ref_size and batch_count sit behind an APB-style port at byte
// addresses 0 and 4 and are to be written by the user only while the block is
// idle; the block itself does not enforce this.
module box_normalized_l1_loss #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bnl_in_if.sink                 in_if,
  bnl_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + 8;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_LANE  = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_BDIV  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [15:0] ref_size_q;
  logic [10:0] batch_count_q;
  logic        cfg_wr;

  // captured input word
  logic [CW-1:0] pred_q [bnl_pkg::LANES];
  logic [CW-1:0] gt_q   [bnl_pkg::LANES];
  logic          eop_q;
  logic          uncov_q;
  logic          wpos_q, hpos_q;

  logic [15:0]   nw_q, nh_q;
  logic [47:0]   loss_sum_q, loss_sum_d;
  logic [47:0]   batch_q;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [33:0]   out_loss_q;
  logic [15:0]   out_wn_q, out_hn_q;
  logic [16:0]   out_grad_q [bnl_pkg::LANES];
  logic [47:0]   out_batch_q;
  logic          out_done_q;

  logic          in_acc;
  logic          out_load;

  // ---------------------------------------------------------------------------
  // configuration port: pready tied high, decode on paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_size_q    <= bnl_pkg::REF_SIZE_RST;
      batch_count_q <= bnl_pkg::BATCH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bnl_pkg::REG_REF_SIZE:    ref_size_q    <= pwdata[15:0];
        bnl_pkg::REG_BATCH_COUNT: batch_count_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bnl_pkg::REG_REF_SIZE:    prdata = {16'd0, ref_size_q};
      bnl_pkg::REG_BATCH_COUNT: prdata = {21'd0, batch_count_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input capture and ground truth extents
  // ---------------------------------------------------------------------------
  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  logic [CW:0] ext_w, ext_h;
  logic        ext_w_pos, ext_h_pos;

  assign ext_w = {in_if.gt_x2[CW-1], in_if.gt_x2} - {in_if.gt_x1[CW-1], in_if.gt_x1};
  assign ext_h = {in_if.gt_y2[CW-1], in_if.gt_y2} - {in_if.gt_y1[CW-1], in_if.gt_y1};
  // a zero or negative extent goes straight to the floor
  assign ext_w_pos = ~ext_w[CW] && (ext_w != '0);
  assign ext_h_pos = ~ext_h[CW] && (ext_h != '0);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pred_q[0] <= in_if.pred_x1;
      pred_q[1] <= in_if.pred_y1;
      pred_q[2] <= in_if.pred_x2;
      pred_q[3] <= in_if.pred_y2;
      gt_q[0]   <= in_if.gt_x1;
      gt_q[1]   <= in_if.gt_y1;
      gt_q[2]   <= in_if.gt_x2;
      gt_q[3]   <= in_if.gt_y2;
      eop_q     <= in_if.end_of_pass;
      uncov_q   <= ~|{in_if.gt_x1, in_if.gt_y1, in_if.gt_x2, in_if.gt_y2};
      wpos_q    <= ext_w_pos;
      hpos_q    <= ext_h_pos;
    end
  end

  // ---------------------------------------------------------------------------
  // norm dividers: extent * 256 / ref_size, width and height side by side
  // ---------------------------------------------------------------------------
  logic          w_done, h_done;
  logic [QW-1:0] w_quot, h_quot;

  bnl_div #(
    .NW (QW),
    .DW (16)
  ) u_div_w (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i ({ext_w[CW-1:0], 8'd0}),
    .divisor_i  (ref_size_q),
    .done_o     (w_done),
    .quot_o     (w_quot)
  );

  bnl_div #(
    .NW (QW),
    .DW (16)
  ) u_div_h (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i ({ext_h[CW-1:0], 8'd0}),
    .divisor_i  (ref_size_q),
    .done_o     (h_done),
    .quot_o     (h_quot)
  );

  // clamp a quotient to the norm range; zero ref_size saturates high
  function automatic logic [15:0] clamp_norm(input logic pos, input logic [15:0] nref,
                                             input logic [QW-1:0] q);
    logic [15:0] r;
    if (!pos) begin
      r = bnl_pkg::NORM_FLOOR;
    end else if (nref == '0) begin
      r = bnl_pkg::NORM_MAX;
    end else if (q < QW'(bnl_pkg::NORM_FLOOR)) begin
      r = bnl_pkg::NORM_FLOOR;
    end else if (q > QW'(bnl_pkg::NORM_MAX)) begin
      r = bnl_pkg::NORM_MAX;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == S_NORM && w_done) begin
      if (uncov_q) begin
        // uncovered location: both norms are one
        nw_q <= bnl_pkg::NORM_ONE;
        nh_q <= bnl_pkg::NORM_ONE;
      end else begin
        nw_q <= clamp_norm(wpos_q, ref_size_q, w_quot);
        nh_q <= clamp_norm(hpos_q, ref_size_q, h_quot);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // coordinate lanes: x lanes use the width norm, y lanes the height norm
  // ---------------------------------------------------------------------------
  logic [CW+15:0] lane_prod [bnl_pkg::LANES];
  logic [16:0]    lane_grad [bnl_pkg::LANES];

  for (genvar i = 0; i < bnl_pkg::LANES; i++) begin : g_lane
    bnl_lane #(
      .W (CW)
    ) u_lane (
      .clk_i  (clk_i),
      .pred_i (pred_q[i]),
      .gt_i   (gt_q[i]),
      .norm_i ((i % 2 == 0) ? nw_q : nh_q),
      .prod_o (lane_prod[i]),
      .grad_o (lane_grad[i])
    );
  end

  // merge stage: registered saturated location loss
  logic [33:0] loss;

  bnl_merge #(
    .W (CW)
  ) u_merge (
    .clk_i   (clk_i),
    .prod_i  (lane_prod),
    .uncov_i (uncov_q),
    .loss_o  (loss)
  );

  // ---------------------------------------------------------------------------
  // accumulator and batch division
  // ---------------------------------------------------------------------------
  logic [48:0] sum_ext;
  logic [47:0] sum_sat;
  logic        b_start;
  logic        b_done;
  logic [47:0] b_quot;
  logic [10:0] b_div;

  assign sum_ext = {1'b0, loss_sum_q} + 49'(loss);
  assign sum_sat = sum_ext[48] ? bnl_pkg::SUM_MAX : sum_ext[47:0];
  assign b_start = (state_q == S_ACC) && eop_q;
  // a zero batch count divides by one
  assign b_div   = (batch_count_q == '0) ? 11'd1 : batch_count_q;

  bnl_div #(
    .NW (48),
    .DW (11)
  ) u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (b_start),
    .dividend_i (sum_sat),
    .divisor_i  (b_div),
    .done_o     (b_done),
    .quot_o     (b_quot)
  );

  always_comb begin
    loss_sum_d = loss_sum_q;
    if (state_q == S_ACC) begin
      loss_sum_d = eop_q ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_sum_q <= '0;
    end else begin
      loss_sum_q <= loss_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ACC) begin
      batch_q <= '0;
    end else if (state_q == S_BDIV && b_done) begin
      batch_q <= b_quot;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_NORM;
      S_NORM:  if (w_done) state_d = S_LANE;
      S_LANE:  state_d = S_MERGE;
      S_MERGE: state_d = S_ACC;
      S_ACC:   state_d = eop_q ? S_BDIV : S_OUT;
      S_BDIV:  if (b_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_loss_q  <= loss;
      out_wn_q    <= nw_q;
      out_hn_q    <= nh_q;
      out_grad_q  <= lane_grad;
      out_batch_q <= batch_q;
      out_done_q  <= eop_q;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.location_loss = out_loss_q;
  assign out_if.width_norm    = out_wn_q;
  assign out_if.height_norm   = out_hn_q;
  assign out_if.grad_x1       = out_grad_q[0];
  assign out_if.grad_y1       = out_grad_q[1];
  assign out_if.grad_x2       = out_grad_q[2];
  assign out_if.grad_y2       = out_grad_q[3];
  assign out_if.batch_loss    = out_batch_q;
  assign out_if.pass_done     = out_done_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // both norm dividers start together and must finish together
  a_norm_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_done |-> h_done)
    else $error("norm dividers out of step");

  // end of pass clears the accumulator
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && eop_q) |=> (loss_sum_q == '0))
    else $error("loss sum not cleared at end of pass");

  // an uncovered location adds no loss
  a_uncov_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE && uncov_q) |=> (loss == '0))
    else $error("uncovered location produced a loss");

  // batch division only finishes while the sequencer waits for it
  a_bdiv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_done |-> (state_q == S_BDIV))
    else $error("batch divider finished out of sequence");

  // a delivered word never carries a norm below the floor
  a_norm_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_wn_q >= bnl_pkg::NORM_FLOOR && out_hn_q >= bnl_pkg::NORM_FLOOR))
    else $error("norm below floor on output");

endmodule
`default_nettype wire

// File: hw/rtl/bnl_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bnl_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   work_q, work_d;
  logic [DW-1:0]   dsr_q, dsr_d;

  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            qbit;

  assign trial = {rem_q, work_q[NW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign qbit  = ~diff[DW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    work_d = work_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      work_d = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DW-1:0] : trial[DW-1:0];
      work_d = {work_q[NW-2:0], qbit};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule
`default_nettype wire

// File: hw/rtl/bnl_lane.sv
// one coordinate lane: weighted absolute difference and gradient
`default_nettype none
module bnl_lane #(
  parameter int unsigned W = 16
) (
  input  wire logic          clk_i,
  input  wire logic [W-1:0]  pred_i,
  input  wire logic [W-1:0]  gt_i,
  input  wire logic [15:0]   norm_i,
  output logic      [W+15:0] prod_o,
  output logic      [16:0]   grad_o
);

  logic [W:0]      diff;
  logic [W:0]      diff_neg;
  logic [W-1:0]    abs_v;
  logic [W+15:0]   prod_d, prod_q;
  logic [16:0]     grad_d, grad_q;

  assign diff     = {pred_i[W-1], pred_i} - {gt_i[W-1], gt_i};
  assign diff_neg = '0 - diff;
  assign abs_v    = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
  assign prod_d   = abs_v * norm_i;

  always_comb begin
    if (diff == '0) begin
      grad_d = '0;
    end else if (diff[W]) begin
      grad_d = 17'd0 - {1'b0, norm_i};
    end else begin
      grad_d = {1'b0, norm_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    grad_q <= grad_d;
  end

  assign prod_o = prod_q;
  assign grad_o = grad_q;

endmodule
`default_nettype wire

// File: hw/rtl/bnl_merge.sv
// merge stage: sums the lane products into a saturated location loss
`default_nettype none
module bnl_merge #(
  parameter int unsigned W = 16
) (
  input  wire logic          clk_i,
  input  wire logic [W+15:0] prod_i [bnl_pkg::LANES],
  input  wire logic          uncov_i,
  output logic      [33:0]   loss_o
);

  localparam int unsigned SumW = (W + 18 > 34) ? W + 18 : 34;

  logic [SumW-1:0] sum;
  logic [33:0]     loss_d, loss_q;

  assign sum = SumW'(prod_i[0]) + SumW'(prod_i[1]) + SumW'(prod_i[2]) + SumW'(prod_i[3]);

  always_comb begin
    if (uncov_i) begin
      loss_d = '0;
    end else if (sum > SumW'(bnl_pkg::LOSS_MAX)) begin
      loss_d = bnl_pkg::LOSS_MAX;
    end else begin
      loss_d = sum[33:0];
    end
  end

  always_ff @(posedge clk_i) begin
    loss_q <= loss_d;
  end

  assign loss_o = loss_q;

endmodule
`default_nettype wire
